// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with reset disable, used by mbe_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and codes shared by the multibrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int PIX_W      = 12;
    localparam int POWER_W    = 4;
    localparam int BAIL_W     = 63;
    localparam int ITER_W     = 16;
    localparam int Q_W        = 32;
    localparam int STEP_W     = 31;
    localparam int FRAC_BITS  = 28;
    localparam int PROD_W     = 2 * Q_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int COLOR_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // exact c: 32-bit origin plus a 43-bit pixel offset
    localparam int C_W        = PIX_W + STEP_W + 2;

    localparam int PALETTE_SIZE = 256;
    localparam int MAX_SIDE     = 4096;

    localparam logic [POWER_W-1:0] MIN_POWER = POWER_W'(2);
    localparam logic [POWER_W-1:0] MAX_POWER = POWER_W'(8);

    localparam logic [COLOR_W-1:0] OFS_Q1 = COLOR_W'(1);
    localparam logic [COLOR_W-1:0] OFS_Q2 = COLOR_W'(PALETTE_SIZE / 4);
    localparam logic [COLOR_W-1:0] OFS_Q3 = COLOR_W'(PALETTE_SIZE / 2);
    localparam logic [COLOR_W-1:0] OFS_Q4 = COLOR_W'((3 * PALETTE_SIZE) / 4);

    localparam logic [POWER_W-1:0]       RST_POWER      = POWER_W'(2);
    localparam logic [BAIL_W-1:0]        RST_BAILOUT_SQ = BAIL_W'(64'h0400_0000_0000_0000);
    localparam logic [ITER_W-1:0]        RST_MAX_ITER   = ITER_W'(256);
    localparam logic                     RST_COLOR_MODE = 1'b0;
    localparam logic signed [Q_W-1:0]    RST_ORIGIN_RE  = -32'sd536870912;
    localparam logic signed [Q_W-1:0]    RST_ORIGIN_IM  = 32'sd402653184;
    localparam logic [STEP_W-1:0]        RST_STEP_RE    = STEP_W'(262144);
    localparam logic [STEP_W-1:0]        RST_STEP_IM    = STEP_W'(262144);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER      = 3'd0,
        REG_BAILOUT_SQ = 3'd1,
        REG_MAX_ITER   = 3'd2,
        REG_COLOR_MODE = 3'd3,
        REG_ORIGIN_RE  = 3'd4,
        REG_ORIGIN_IM  = 3'd5,
        REG_STEP_RE    = 3'd6,
        REG_STEP_IM    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [POWER_W-1:0]    power;
        logic [BAIL_W-1:0]     bailout_sq;
        logic [ITER_W-1:0]     max_iter;
        logic                  color_mode;
        logic signed [Q_W-1:0] origin_re;
        logic signed [Q_W-1:0] origin_im;
        logic [STEP_W-1:0]     step_re;
        logic [STEP_W-1:0]     step_im;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_index;
        logic               inside_set;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_C1,
        S_C2,
        S_C3,
        S_CHK,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_ADD,
        S_Q1,
        S_Q2,
        S_Q3,
        S_Q4,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MS_PX,
        MS_PY,
        MS_WR_ZR,
        MS_WI_ZI,
        MS_WR_ZI,
        MS_WI_ZR,
        MS_ZR_ZR,
        MS_ZI_ZI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     pix_ld;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     cre_ld;
        logic     cim_ld;
        logic     w_init;
        logic     w_re_ld;
        logic     w_im_ld;
        logic     z_ld;
        logic     cnt_inc;
        logic     out_ld;
        logic     out_inside;
    } dp_cmd_t;

    typedef struct packed {
        logic c_fit;
        logic cnt_at_limit;
        logic cnt_last;
        logic cmul_ok;
        logic add_ok;
        logic mag_esc;
    } dp_sts_t;

endpackage

// ===== design/mbe_dp.sv =====
// ----------------------------------------------------------------------------
// mbe_dp
// Datapath: shared 32x32 multiplier, 65-bit accumulator, point and orbit
// registers, iteration counter and palette offset.
// ----------------------------------------------------------------------------
module mbe_dp
    import mbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  pixel_t               pixel,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic [COLOR_W-1:0]   color
);

    logic [PIX_W-1:0]         px_reg;
    logic [PIX_W-1:0]         py_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [Q_W-1:0]    mul_a;
    logic signed [Q_W-1:0]    mul_b;
    logic signed [Q_W-1:0]    cr_reg;
    logic signed [Q_W-1:0]    ci_reg;
    logic signed [Q_W-1:0]    wr_reg;
    logic signed [Q_W-1:0]    wi_reg;
    logic signed [Q_W-1:0]    zr_reg;
    logic signed [Q_W-1:0]    zi_reg;
    logic                     cr_fit_reg;
    logic                     c_fit_reg;
    logic                     re_fit_reg;
    logic                     zr_pos_reg;
    logic                     zi_pos_reg;
    logic                     zi_neg_reg;
    logic [ITER_W-1:0]        count_reg;
    logic signed [C_W-1:0]    cr_full;
    logic signed [C_W-1:0]    ci_full;
    logic                     cr_fit;
    logic                     ci_fit;
    logic                     acc_fit;
    logic signed [Q_W-1:0]    acc_floor;
    logic signed [Q_W:0]      nr_sum;
    logic signed [Q_W:0]      ni_sum;
    logic                     add_ok;
    logic [COLOR_W-1:0]       ofs;

    always_comb
    begin
        case (cmd.mul_sel)
            MS_PX:
            begin
                mul_a = {{(Q_W-PIX_W){1'b0}}, px_reg};
                mul_b = {1'b0, cfg.step_re};
            end
            MS_PY:
            begin
                mul_a = {{(Q_W-PIX_W){1'b0}}, py_reg};
                mul_b = {1'b0, cfg.step_im};
            end
            MS_WR_ZR:
            begin
                mul_a = wr_reg;
                mul_b = zr_reg;
            end
            MS_WI_ZI:
            begin
                mul_a = wi_reg;
                mul_b = zi_reg;
            end
            MS_WR_ZI:
            begin
                mul_a = wr_reg;
                mul_b = zi_reg;
            end
            MS_WI_ZR:
            begin
                mul_a = wi_reg;
                mul_b = zr_reg;
            end
            MS_ZR_ZR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            MS_ZI_ZI:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = wr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {prod_reg[PROD_W-1], prod_reg};

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // floor shift of the accumulator and Q4.28 range check
    assign acc_floor = acc_reg[FRAC_BITS+Q_W-1:FRAC_BITS];
    assign acc_fit   = (&acc_reg[ACC_W-1:FRAC_BITS+Q_W-1])
                     | (~|acc_reg[ACC_W-1:FRAC_BITS+Q_W-1]);

    // c from origin and pixel offset held in the product register
    assign cr_full = {{(C_W-Q_W){cfg.origin_re[Q_W-1]}}, cfg.origin_re}
                   + prod_reg[C_W-1:0];
    assign ci_full = {{(C_W-Q_W){cfg.origin_im[Q_W-1]}}, cfg.origin_im}
                   - prod_reg[C_W-1:0];
    assign cr_fit  = (&cr_full[C_W-1:Q_W-1]) | (~|cr_full[C_W-1:Q_W-1]);
    assign ci_fit  = (&ci_full[C_W-1:Q_W-1]) | (~|ci_full[C_W-1:Q_W-1]);

    assign nr_sum = {wr_reg[Q_W-1], wr_reg} + {cr_reg[Q_W-1], cr_reg};
    assign ni_sum = {wi_reg[Q_W-1], wi_reg} + {ci_reg[Q_W-1], ci_reg};
    assign add_ok = (nr_sum[Q_W] == nr_sum[Q_W-1]) && (ni_sum[Q_W] == ni_sum[Q_W-1]);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.pix_ld)
        begin
            px_reg <= PIX_W'(pixel.pixel_x % MAX_SIDE);
            py_reg <= PIX_W'(pixel.pixel_y % MAX_SIDE);
        end
        if (cmd.cre_ld)
        begin
            cr_reg     <= cr_full[Q_W-1:0];
            cr_fit_reg <= cr_fit;
            zr_pos_reg <= !cr_full[C_W-1] && (|cr_full);
        end
        if (cmd.cim_ld)
        begin
            ci_reg     <= ci_full[Q_W-1:0];
            c_fit_reg  <= cr_fit_reg && ci_fit;
            zr_reg     <= cr_reg;
            zi_reg     <= ci_full[Q_W-1:0];
            zi_pos_reg <= !ci_full[C_W-1] && (|ci_full);
            zi_neg_reg <= ci_full[C_W-1];
        end
        if (cmd.w_init)
        begin
            wr_reg <= zr_reg;
            wi_reg <= zi_reg;
        end
        if (cmd.w_re_ld)
        begin
            wr_reg     <= acc_floor;
            re_fit_reg <= acc_fit;
        end
        if (cmd.w_im_ld)
        begin
            wi_reg <= acc_floor;
        end
        if (cmd.z_ld && add_ok)
        begin
            zr_reg     <= nr_sum[Q_W-1:0];
            zi_reg     <= ni_sum[Q_W-1:0];
            zr_pos_reg <= !nr_sum[Q_W-1] && (|nr_sum[Q_W-1:0]);
            zi_pos_reg <= !ni_sum[Q_W-1] && (|ni_sum[Q_W-1:0]);
            zi_neg_reg <= ni_sum[Q_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.pix_ld)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg <= count_reg + ITER_W'(1);
        end
    end

    always_comb
    begin
        if (zr_pos_reg && zi_pos_reg)
        begin
            ofs = OFS_Q1;
        end
        else if (!zr_pos_reg && zi_pos_reg)
        begin
            ofs = OFS_Q2;
        end
        else if (!zr_pos_reg && zi_neg_reg)
        begin
            ofs = OFS_Q3;
        end
        else
        begin
            ofs = OFS_Q4;
        end
    end

    assign color = COLOR_W'(count_reg) + (cfg.color_mode ? ofs : '0);

    assign sts.c_fit        = c_fit_reg;
    assign sts.cnt_at_limit = count_reg >= cfg.max_iter;
    assign sts.cnt_last     = ({1'b0, count_reg} + (ITER_W+1)'(1)) >= {1'b0, cfg.max_iter};
    assign sts.cmul_ok      = re_fit_reg && acc_fit;
    assign sts.add_ok       = add_ok;
    assign sts.mag_esc      = $unsigned(acc_reg) > {2'b00, cfg.bailout_sq};

endmodule

// ===== design/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: steps the datapath through point setup, the chain of complex
// products, the add of c and the magnitude test, and hands off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  logic [POWER_W-1:0] power,
    input  logic               out_free,
    input  dp_sts_t            sts,
    output dp_cmd_t            cmd
);

    state_t             state_reg;
    state_t             state_next;
    logic [POWER_W-1:0] k_reg;
    logic [POWER_W-1:0] k_next;
    logic               inside_reg;
    logic               inside_next;
    logic [POWER_W-1:0] n_eff;
    logic               more_mul;

    assign n_eff = (power < MIN_POWER) ? MIN_POWER :
                   (power > MAX_POWER) ? MAX_POWER : power;

    assign more_mul = ({1'b0, k_reg} + (POWER_W+1)'(1)) < {1'b0, n_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            inside_reg <= inside_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        inside_next = inside_reg;
        pixel_ready = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MS_WR_ZR;
        cmd.acc_op  = ACC_HOLD;
        cmd.out_inside = inside_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.pix_ld = 1'b1;
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                cmd.mul_sel = MS_PX;
                state_next  = S_C2;
            end
            S_C2:
            begin
                cmd.mul_sel = MS_PY;
                cmd.cre_ld  = 1'b1;
                state_next  = S_C3;
            end
            S_C3:
            begin
                cmd.cim_ld = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!sts.c_fit)
                begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (sts.cnt_at_limit)
                begin
                    inside_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.w_init = 1'b1;
                    k_next     = POWER_W'(1);
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                cmd.mul_sel = MS_WR_ZR;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.mul_sel = MS_WI_ZI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.mul_sel = MS_WR_ZI;
                cmd.acc_op  = ACC_SUB;
                state_next  = S_M4;
            end
            S_M4:
            begin
                cmd.mul_sel = MS_WI_ZR;
                cmd.acc_op  = ACC_LOAD;
                cmd.w_re_ld = 1'b1;
                state_next  = S_M5;
            end
            S_M5:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_M6;
            end
            S_M6:
            begin
                cmd.w_im_ld = 1'b1;
                if (!sts.cmul_ok)
                begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (more_mul)
                begin
                    k_next     = k_reg + POWER_W'(1);
                    state_next = S_M1;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.z_ld = 1'b1;
                if (!sts.add_ok)
                begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_Q1;
                end
            end
            S_Q1:
            begin
                cmd.mul_sel = MS_ZR_ZR;
                state_next  = S_Q2;
            end
            S_Q2:
            begin
                cmd.mul_sel = MS_ZI_ZI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_Q3;
            end
            S_Q3:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_Q4;
            end
            S_Q4:
            begin
                if (sts.mag_esc)
                begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    if (sts.cnt_last)
                    begin
                        inside_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.w_init = 1'b1;
                        k_next     = POWER_W'(1);
                        state_next = S_M1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_out_slot_free, clk, rst_n, cmd.out_ld, out_free)
    `ASSERT_IMPLIES(a_k_range, clk, rst_n, state_reg == S_M1, (k_reg != '0) && (k_reg < n_eff))
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, pixel_valid && pixel_ready, state_reg == S_C1)

endmodule

// ===== design/multibrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// multibrot_escape_time_top
// Multibrot escape-time point evaluator: maps a pixel to c, iterates
// z = z^n + c in Q4.28 and returns the escape count and inside flag.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  pixel     in   pixel_valid/pixel_ready   pixel_t  (pixel_x, pixel_y)
//  result    out  result_valid/result_ready result_t (color_index, inside_set)
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  One item at a time: point setup, then per iteration the chain of
//  complex products on the shared 32x32 multiplier, the add of c and the
//  magnitude test, then hand-off. The result register takes the finished
//  item; the next pixel is taken while that result waits. Config writes
//  complete every cycle. Reset restores register defaults and empties
//  the result register.
// ----------------------------------------------------------------------------
module multibrot_escape_time_top
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pixel_t                pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic [COLOR_W-1:0] color;
    logic               result_valid_reg;
    result_t            result_reg;
    logic               out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power      <= RST_POWER;
            cfg_reg.bailout_sq <= RST_BAILOUT_SQ;
            cfg_reg.max_iter   <= RST_MAX_ITER;
            cfg_reg.color_mode <= RST_COLOR_MODE;
            cfg_reg.origin_re  <= RST_ORIGIN_RE;
            cfg_reg.origin_im  <= RST_ORIGIN_IM;
            cfg_reg.step_re    <= RST_STEP_RE;
            cfg_reg.step_im    <= RST_STEP_IM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POWER:      cfg_reg.power      <= cfg_data[POWER_W-1:0];
                REG_BAILOUT_SQ: cfg_reg.bailout_sq <= cfg_data[BAIL_W-1:0];
                REG_MAX_ITER:   cfg_reg.max_iter   <= cfg_data[ITER_W-1:0];
                REG_COLOR_MODE: cfg_reg.color_mode <= cfg_data[0];
                REG_ORIGIN_RE:  cfg_reg.origin_re  <= cfg_data[Q_W-1:0];
                REG_ORIGIN_IM:  cfg_reg.origin_im  <= cfg_data[Q_W-1:0];
                REG_STEP_RE:    cfg_reg.step_re    <= cfg_data[STEP_W-1:0];
                REG_STEP_IM:    cfg_reg.step_im    <= cfg_data[STEP_W-1:0];
                default:        cfg_reg.power      <= cfg_reg.power;
            endcase
        end
    end

    assign out_free = !result_valid_reg || result_ready;

    mbe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .power       (cfg_reg.power),
        .out_free    (out_free),
        .sts         (sts),
        .cmd         (cmd)
    );

    mbe_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .pixel (pixel),
        .cmd   (cmd),
        .sts   (sts),
        .color (color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            result_reg.color_index <= color;
            result_reg.inside_set  <= cmd.out_inside;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== test/mbe_escape_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_escape_checker
// Watches the pixel, result and register channels of the multibrot
// escape-time block. Keeps its own copy of the registers, predicts the
// escape count and inside flag of each accepted pixel in Q4.28 and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mbe_escape_checker
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  logic                  pixel_ready,
    input  pixel_t                pixel,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    in_flight
);

    typedef logic signed [79:0] wide_t;

    localparam wide_t Q_MAX = 80'sd2147483647;
    localparam wide_t Q_MIN = -80'sd2147483648;

    cfg_t    settings;
    result_t escape_queue[$];
    result_t want;

    function automatic bit in_q4_28(input wide_t v);
        return v >= Q_MIN && v <= Q_MAX;
    endfunction

    // complex product, floor rounding; 0 when a part leaves Q4.28
    function automatic bit mul_q4_28(input wide_t a, input wide_t b,
                                     input wide_t c, input wide_t d,
                                     output wide_t re, output wide_t im);
        re = (a * c - b * d) >>> FRAC_BITS;
        im = (a * d + b * c) >>> FRAC_BITS;
        return in_q4_28(re) && in_q4_28(im);
    endfunction

    function automatic result_t predict_escape(input pixel_t p, input cfg_t s);
        wide_t              cr;
        wide_t              ci;
        wide_t              zr;
        wide_t              zi;
        wide_t              wr;
        wide_t              wi;
        wide_t              nr;
        wide_t              ni;
        int unsigned        n;
        int unsigned        k;
        int unsigned        iter;
        bit                 ok;
        bit                 in_set;
        bit                 done;
        logic [COLOR_W-1:0] offset;
        result_t            r;
        cr = wide_t'(s.origin_re) + wide_t'(p.pixel_x) * wide_t'(s.step_re);
        ci = wide_t'(s.origin_im) - wide_t'(p.pixel_y) * wide_t'(s.step_im);
        n = s.power;
        if (n < MIN_POWER)
            n = MIN_POWER;
        if (n > MAX_POWER)
            n = MAX_POWER;
        zr = cr;
        zi = ci;
        iter = 0;
        in_set = 1'b1;
        done = 1'b0;
        if (!in_q4_28(cr) || !in_q4_28(ci))
            in_set = 1'b0;
        else
        begin
            while (!done && iter < s.max_iter)
            begin
                wr = zr;
                wi = zi;
                ok = 1'b1;
                for (k = 1; k < n && ok; k++)
                    ok = mul_q4_28(wr, wi, zr, zi, wr, wi);
                if (ok)
                begin
                    nr = wr + cr;
                    ni = wi + ci;
                    ok = in_q4_28(nr) && in_q4_28(ni);
                end
                if (!ok)
                begin
                    in_set = 1'b0;
                    done = 1'b1;
                end
                else
                begin
                    zr = nr;
                    zi = ni;
                    if (nr * nr + ni * ni > wide_t'(s.bailout_sq))
                    begin
                        in_set = 1'b0;
                        done = 1'b1;
                    end
                    else
                        iter++;
                end
            end
        end
        offset = '0;
        if (s.color_mode)
        begin
            if (zr > 0 && zi > 0)
                offset = OFS_Q1;
            else if (zr <= 0 && zi > 0)
                offset = OFS_Q2;
            else if (zr <= 0 && zi < 0)
                offset = OFS_Q3;
            else
                offset = OFS_Q4;
        end
        r.color_index = COLOR_W'(iter) + offset;
        r.inside_set = in_set;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.power = RST_POWER;
            settings.bailout_sq = RST_BAILOUT_SQ;
            settings.max_iter = RST_MAX_ITER;
            settings.color_mode = RST_COLOR_MODE;
            settings.origin_re = RST_ORIGIN_RE;
            settings.origin_im = RST_ORIGIN_IM;
            settings.step_re = RST_STEP_RE;
            settings.step_im = RST_STEP_IM;
            escape_queue.delete();
            mismatches = 0;
            in_flight = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (escape_queue.size() == 0)
                begin
                    $error("result item with no pixel outstanding");
                    mismatches++;
                end
                else
                begin
                    want = escape_queue.pop_front();
                    if (result.color_index !== want.color_index)
                    begin
                        $error("color_index expected %0d got %0d",
                               want.color_index, result.color_index);
                        mismatches++;
                    end
                    if (result.inside_set !== want.inside_set)
                    begin
                        $error("inside_set expected %0d got %0d",
                               want.inside_set, result.inside_set);
                        mismatches++;
                    end
                end
            end
            if (pixel_valid && pixel_ready)
                escape_queue.push_back(predict_escape(pixel, settings));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_POWER:      settings.power = cfg_data[POWER_W-1:0];
                    REG_BAILOUT_SQ: settings.bailout_sq = cfg_data[BAIL_W-1:0];
                    REG_MAX_ITER:   settings.max_iter = cfg_data[ITER_W-1:0];
                    REG_COLOR_MODE: settings.color_mode = cfg_data[0];
                    REG_ORIGIN_RE:  settings.origin_re = cfg_data[Q_W-1:0];
                    REG_ORIGIN_IM:  settings.origin_im = cfg_data[Q_W-1:0];
                    REG_STEP_RE:    settings.step_re = cfg_data[STEP_W-1:0];
                    REG_STEP_IM:    settings.step_im = cfg_data[STEP_W-1:0];
                endcase
            end
            in_flight = escape_queue.size();
        end
    end

endmodule

// ===== test/multibrot_escape_time_top_tb.sv =====
// ----------------------------------------------------------------------------
// multibrot_escape_time_top_tb
// Drives pixels through the escape-time block under a series of register
// views: reset defaults, directed corner views (clamped powers, a zero
// iteration limit, points and orbits outside Q4.28, all quadrants), then
// random views with random pixels, one at the full iteration limit. Both
// sides idle at random, the receiver once holds off long enough to back up
// the block, and a watchdog ends a run that stops moving. The checker
// beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module multibrot_escape_time_top_tb;
    import mbe_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_VIEWS    = 20;
    localparam int PIXELS_PER_VIEW = 50;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    pixel_t                pixel;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    in_flight;
    int unsigned           hold_requests = 0;
    bit                    idle_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multibrot_escape_time_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mbe_escape_checker escape_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    function automatic logic [PIX_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel <= {x, y};
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // drop valid and hold until every predicted result is back
    task automatic wait_for_results();
        @(negedge clk);
        pixel_valid <= 1'b0;
        wait (in_flight == 0);
        repeat (4) @(negedge clk);
    endtask

    // fill unused data bits with noise
    task automatic write_register(input cfg_idx_t idx, input logic [63:0] value,
                                  input int width);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ((noise >> width) << width) | (value & ((64'd1 << width) - 64'd1));
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_view(input cfg_t s);
        write_register(REG_POWER, 64'(s.power), POWER_W);
        write_register(REG_BAILOUT_SQ, 64'(s.bailout_sq), BAIL_W);
        write_register(REG_MAX_ITER, 64'(s.max_iter), ITER_W);
        write_register(REG_COLOR_MODE, 64'(s.color_mode), 1);
        write_register(REG_ORIGIN_RE, 64'(s.origin_re), Q_W);
        write_register(REG_ORIGIN_IM, 64'(s.origin_im), Q_W);
        write_register(REG_STEP_RE, 64'(s.step_re), STEP_W);
        write_register(REG_STEP_IM, 64'(s.step_im), STEP_W);
    endtask

    initial
    begin
        int unsigned pause;
        int unsigned holds_done;
        holds_done = 0;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_requests != holds_done)
            begin
                pause = LONG_HOLD;
                holds_done = hold_requests;
            end
            else
                pause = idle_on ? $urandom_range(0, 4) : 0;
            repeat (pause)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("multibrot_escape_time_top verification failed");
        $finish;
    end

    initial
    begin
        cfg_t s;
        int   view;
        int   i;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset view: corners, the origin point and a point inside the set
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd1536);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1536, 12'd1536);
        wait_for_results();

        // power below range, zero iteration limit, all quadrants and axes
        s.power = 4'd0;
        s.bailout_sq = RST_BAILOUT_SQ;
        s.max_iter = '0;
        s.color_mode = 1'b1;
        s.origin_re = RST_ORIGIN_RE;
        s.origin_im = RST_ORIGIN_IM;
        s.step_re = RST_STEP_RE;
        s.step_im = RST_STEP_IM;
        load_view(s);
        send_pixel(12'd3000, 12'd100);
        send_pixel(12'd100, 12'd100);
        send_pixel(12'd100, 12'd3000);
        send_pixel(12'd3000, 12'd3000);
        send_pixel(12'd2048, 12'd1536);
        wait_for_results();

        // power above range, c beyond Q4.28, overflow in the first iteration
        s.power = 4'd9;
        s.bailout_sq = '1;
        s.max_iter = 16'd5;
        s.color_mode = 1'b1;
        s.origin_re = 32'h7FFF_FFFF;
        s.origin_im = 32'h8000_0000;
        s.step_re = '1;
        s.step_im = '1;
        load_view(s);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd4095, 12'd4095);
        wait_for_results();

        // zero bailout with c stuck at zero
        s.power = 4'd15;
        s.bailout_sq = '0;
        s.max_iter = 16'd3;
        s.color_mode = 1'b0;
        s.origin_re = '0;
        s.origin_im = '0;
        s.step_re = '0;
        s.step_im = '0;
        load_view(s);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd123, 12'd2000);
        wait_for_results();

        s.power = 4'd1;
        s.bailout_sq = RST_BAILOUT_SQ;
        s.max_iter = 16'd4;
        s.color_mode = 1'b1;
        s.origin_re = 32'h8000_0000;
        s.origin_im = 32'h7FFF_FFFF;
        s.step_re = '0;
        s.step_im = '1;
        load_view(s);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd7, 12'd1);
        send_pixel(12'd0, 12'd4095);
        wait_for_results();

        for (view = 0; view < RANDOM_VIEWS; view++)
        begin
            s.power = POWER_W'($urandom_range(0, 15));
            case ($urandom_range(0, 4))
                0:       s.bailout_sq = '0;
                1:       s.bailout_sq = RST_BAILOUT_SQ;
                2:       s.bailout_sq = '1;
                3:       s.bailout_sq = BAIL_W'({$urandom(), $urandom()});
                default: s.bailout_sq = BAIL_W'($urandom()) << $urandom_range(16, 31);
            endcase
            s.max_iter = ($urandom_range(0, 3) == 0) ? ITER_W'(1)
                                                     : ITER_W'($urandom_range(0, 20));
            s.color_mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:
                begin
                    s.origin_re = $urandom();
                    s.origin_im = $urandom();
                    s.step_re = STEP_W'($urandom());
                    s.step_im = STEP_W'($urandom());
                end
                1:
                begin
                    s.origin_re = 32'($urandom_range(0, 32'h3000_0000)) - 32'h2000_0000;
                    s.origin_im = 32'($urandom_range(0, 32'h3000_0000)) - 32'h1800_0000;
                    s.step_re = STEP_W'($urandom_range(0, 4096));
                    s.step_im = STEP_W'($urandom_range(0, 4096));
                end
                default:
                begin
                    s.origin_re = 32'($urandom_range(0, 32'h1000_0000)) - 32'h2800_0000;
                    s.origin_im = 32'h1400_0000 + 32'($urandom_range(0, 32'h0800_0000));
                    s.step_re = STEP_W'($urandom_range(32'h1_0000, 32'h8_0000));
                    s.step_im = STEP_W'($urandom_range(32'h1_0000, 32'h8_0000));
                end
            endcase
            // full iteration limit; every c has |c| >= 3 so it escapes at once
            if (view == 1)
            begin
                s.max_iter = '1;
                s.bailout_sq = RST_BAILOUT_SQ;
                s.origin_re = 32'h3000_0000;
                s.step_re = STEP_W'(32'h1000_0000);
            end
            // short items so the block backs up behind the long hold
            if (view == 2)
            begin
                s.power = MIN_POWER;
                s.max_iter = 16'd8;
            end
            idle_on = ($urandom_range(0, 3) != 0);
            load_view(s);
            if (view == 2)
                hold_requests++;
            for (i = 0; i < PIXELS_PER_VIEW; i++)
                send_pixel(pick_coord(), pick_coord());
            wait_for_results();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("multibrot_escape_time_top verification clean");
        else
            $display("multibrot_escape_time_top verification failed");
        $finish;
    end

endmodule
